### design/assert_macros.svh
// Assertion macros shared by the divider, output and top-level design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at each clock edge outside reset
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property at each clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/dec_pkg.sv
// Types, constants and helpers for the disc collision pipeline
package dec_pkg;

  localparam int unsigned CdWidth  = 15;
  localparam int unsigned CcWidth  = 2 * CdWidth;
  localparam logic [CdWidth-1:0] CdReset = CdWidth'(410);
  localparam int unsigned NumWidth = 50;
  localparam int unsigned DenWidth = CcWidth + 1;
  localparam int unsigned QWidth   = 19;

  typedef struct packed {
    logic signed [15:0] first_pos_x;
    logic signed [15:0] first_pos_y;
    logic signed [15:0] second_pos_x;
    logic signed [15:0] second_pos_y;
    logic signed [15:0] first_vel_x;
    logic signed [15:0] first_vel_y;
    logic signed [15:0] second_vel_x;
    logic signed [15:0] second_vel_y;
    logic [3:0]         first_id;
    logic [3:0]         second_id;
    logic [4:0]         first_last_hit;
    logic [4:0]         second_last_hit;
  } item_t;

  typedef struct packed {
    logic signed [15:0] first_new_vx;
    logic signed [15:0] first_new_vy;
    logic signed [15:0] second_new_vx;
    logic signed [15:0] second_new_vy;
    logic               collided;
  } result_t;

  typedef struct packed {
    logic               hit;
    logic               negx;
    logic               negy;
    logic signed [15:0] v1x;
    logic signed [15:0] v1y;
    logic signed [15:0] v2x;
    logic signed [15:0] v2y;
  } side_t;

  typedef struct packed {
    logic [NumWidth-1:0] numx;
    logic [NumWidth-1:0] numy;
    logic [DenWidth-1:0] den;
    side_t               side;
  } div_in_t;

  typedef struct packed {
    logic [QWidth-1:0] qx;
    logic [QWidth-1:0] qy;
    side_t             side;
  } div_out_t;

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    logic signed [15:0] r;
    if (v > 21'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -21'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### design/dec_front.sv
// Front pipeline: differences, squared distance, contact test, numerators
module dec_front
  import dec_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  item_t               item,
  input  logic [CcWidth-1:0]  cc,
  output logic                dn_valid,
  input  logic                dn_ready,
  output div_in_t             dn
);

  logic va, vb, vc, vd, ve;
  logic en_a, en_b, en_c, en_d, en_e;

  logic signed [16:0] a_dx, a_dy, a_dvx, a_dvy;
  logic               a_skip;
  side_t              a_side;

  logic [33:0]        b_dxx, b_dyy;
  logic signed [33:0] b_sx, b_sy;
  logic signed [16:0] b_dx, b_dy;
  logic               b_skip;
  side_t              b_side;

  logic [34:0]        c_dd_next;
  logic signed [34:0] c_s_next;
  logic [34:0]        c_smag_full;
  logic [16:0]        c_dxm_full, c_dym_full;
  side_t              c_side_next;
  logic [CcWidth-1:0] c_dd;
  logic [32:0]        c_smag;
  logic [14:0]        c_dxm, c_dym;
  logic               c_sneg, c_dxneg, c_dyneg;
  side_t              c_side;

  side_t              d_side_next;
  logic [31:0]        d_pxl, d_pyl;
  logic [30:0]        d_pxh, d_pyh;
  logic [CcWidth-1:0] d_dd;
  side_t              d_side;

  logic [47:0]        e_magx, e_magy;

  assign en_e = !ve || dn_ready;
  assign en_d = !vd || en_e;
  assign en_c = !vc || en_d;
  assign en_b = !vb || en_c;
  assign en_a = !va || en_b;
  assign item_stall = !en_a;
  assign dn_valid = ve;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else begin
      if (en_a) va <= item_valid;
      if (en_b) vb <= va;
      if (en_c) vc <= vb;
      if (en_d) vd <= vc;
      if (en_e) ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_dx   <= 17'(item.first_pos_x) - 17'(item.second_pos_x);
      a_dy   <= 17'(item.first_pos_y) - 17'(item.second_pos_y);
      a_dvx  <= 17'(item.second_vel_x) - 17'(item.first_vel_x);
      a_dvy  <= 17'(item.second_vel_y) - 17'(item.first_vel_y);
      a_skip <= (item.first_last_hit == {1'b0, item.second_id}) &&
                (item.second_last_hit == {1'b0, item.first_id});
      a_side <= '{hit: 1'b0, negx: 1'b0, negy: 1'b0,
                  v1x: item.first_vel_x, v1y: item.first_vel_y,
                  v2x: item.second_vel_x, v2y: item.second_vel_y};
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_dxx  <= 34'(a_dx * a_dx);
      b_dyy  <= 34'(a_dy * a_dy);
      b_sx   <= a_dvx * a_dx;
      b_sy   <= a_dvy * a_dy;
      b_dx   <= a_dx;
      b_dy   <= a_dy;
      b_skip <= a_skip;
      b_side <= a_side;
    end
  end

  always_comb begin
    c_dd_next   = 35'(b_dxx) + 35'(b_dyy);
    c_s_next    = 35'(b_sx) + 35'(b_sy);
    c_smag_full = c_s_next[34] ? 35'(-c_s_next) : 35'(c_s_next);
    c_dxm_full  = b_dx[16] ? 17'(-b_dx) : 17'(b_dx);
    c_dym_full  = b_dy[16] ? 17'(-b_dy) : 17'(b_dy);
    c_side_next     = b_side;
    c_side_next.hit = !b_skip && (c_dd_next != 35'd0) && (c_dd_next < 35'(cc));
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_dd        <= c_dd_next[CcWidth-1:0];
      c_smag      <= c_smag_full[32:0];
      c_sneg      <= c_s_next[34];
      c_dxm       <= c_dxm_full[14:0];
      c_dym       <= c_dym_full[14:0];
      c_dxneg     <= b_dx[16];
      c_dyneg     <= b_dy[16];
      c_side      <= c_side_next;
    end
  end

  always_comb begin
    d_side_next      = c_side;
    d_side_next.negx = c_dxneg ^ c_sneg;
    d_side_next.negy = c_dyneg ^ c_sneg;
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_pxl       <= 32'(c_dxm * c_smag[16:0]);
      d_pxh       <= 31'(c_dxm * c_smag[32:17]);
      d_pyl       <= 32'(c_dym * c_smag[16:0]);
      d_pyh       <= 31'(c_dym * c_smag[32:17]);
      d_dd        <= c_dd;
      d_side      <= d_side_next;
    end
  end

  always_comb begin
    e_magx = {d_pxh, 17'b0} + 48'(d_pxl);
    e_magy = {d_pyh, 17'b0} + 48'(d_pyl);
  end

  always_ff @(posedge clk) begin
    if (en_e) begin
      dn.numx <= {e_magx, 1'b0} + NumWidth'(d_dd);
      dn.numy <= {e_magy, 1'b0} + NumWidth'(d_dd);
      dn.den  <= {d_dd, 1'b0};
      dn.side <= d_side;
    end
  end

endmodule

### design/dec_div.sv
// Pipelined restoring divider, one quotient bit per stage for both components
module dec_div
  import dec_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  output logic      up_ready,
  input  div_in_t   up,
  output logic      dn_valid,
  input  logic      dn_ready,
  output div_out_t  dn
);

  `include "assert_macros.svh"

  typedef struct packed {
    logic [NumWidth-1:0] remx;
    logic [NumWidth-1:0] remy;
    logic [QWidth-1:0]   qx;
    logic [QWidth-1:0]   qy;
    logic [DenWidth-1:0] den;
    side_t               side;
  } stage_t;

  logic   [QWidth-1:0] v;
  logic   [QWidth-1:0] en;
  stage_t              st     [QWidth];
  stage_t              src    [QWidth];
  stage_t              st_next[QWidth];

  assign src[0] = '{remx: up.numx, remy: up.numy, qx: '0, qy: '0,
                    den: up.den, side: up.side};

  for (genvar k = 0; k < QWidth; k++) begin : g_stage
    localparam int unsigned Sh = QWidth - 1 - k;
    logic [NumWidth-1:0] trial;

    if (k > 0) begin : g_link
      assign src[k] = st[k-1];
    end
    if (k == QWidth - 1) begin : g_last
      assign en[k] = !v[k] || dn_ready;
    end else begin : g_mid
      assign en[k] = !v[k] || en[k+1];
    end

    assign trial = NumWidth'(src[k].den) << Sh;

    always_comb begin
      st_next[k] = src[k];
      if (src[k].remx >= trial) begin
        st_next[k].remx  = src[k].remx - trial;
        st_next[k].qx[Sh] = 1'b1;
      end
      if (src[k].remy >= trial) begin
        st_next[k].remy  = src[k].remy - trial;
        st_next[k].qy[Sh] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= (k == 0) ? up_valid : v[(k == 0) ? 0 : k - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st[k] <= st_next[k];
      end
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v[QWidth-1];
  assign dn = '{qx: st[QWidth-1].qx, qy: st[QWidth-1].qy, side: st[QWidth-1].side};

  `ASSERT_CHK(a_last_holds,
    v[QWidth-1] && !en[QWidth-1] |=> v[QWidth-1] && $stable(st[QWidth-1]),
    "divider output stage changed while held")

endmodule

### design/dec_out.sv
// Output stage: signed correction, velocity update, saturation, result register
module dec_out
  import dec_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_ready,
  input  div_out_t up,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result
);

  `include "assert_macros.svh"

  logic signed [19:0] ex, ey;
  result_t            result_next;

  assign up_ready = !result_valid || !result_stall;

  always_comb begin
    ex = up.side.negx ? -20'(up.qx) : 20'(up.qx);
    ey = up.side.negy ? -20'(up.qy) : 20'(up.qy);
    if (up.side.hit) begin
      result_next.first_new_vx  = sat16(21'(up.side.v1x) + 21'(ex));
      result_next.first_new_vy  = sat16(21'(up.side.v1y) + 21'(ey));
      result_next.second_new_vx = sat16(21'(up.side.v2x) - 21'(ex));
      result_next.second_new_vy = sat16(21'(up.side.v2y) - 21'(ey));
    end else begin
      result_next.first_new_vx  = up.side.v1x;
      result_next.first_new_vy  = up.side.v1y;
      result_next.second_new_vx = up.side.v2x;
      result_next.second_new_vy = up.side.v2y;
    end
    result_next.collided = up.side.hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (up_ready) begin
      result_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      result <= result_next;
    end
  end

  `ASSERT_CHK(a_quot_range,
    up_valid && up.side.hit |-> !up.qx[QWidth-1] && !up.qy[QWidth-1],
    "velocity correction out of range")

endmodule

### design/disc_elastic_collision.sv
// Top level of the equal-mass disc collision pipeline
//
//  channel  | handshake               | payload
//  item     | item_valid / item_stall | item (item_t)
//  result   | result_valid / result_stall | result (result_t)
//  config   | cfg_wen                 | cfg_wdata (contact distance)
//
// An item transfer loads the first of 25 register stages: five front stages,
// nineteen divider stages and the result register; one transfer per cycle is
// sustained while result_stall stays low.
// The divider pipeline, one quotient bit per stage, sets the depth.
// Synchronous reset empties every stage and loads the contact distance 410 (CdReset).
// A stall holds only filled stages; empty slots keep taking transfers.
module disc_elastic_collision
  import dec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_stall,
  output result_t            result,
  input  logic               cfg_wen,
  input  logic [CdWidth-1:0] cfg_wdata
);

  `include "assert_macros.svh"

  logic [CcWidth-1:0] cc;
  logic               f_valid, f_ready, d_valid, d_ready;
  div_in_t            f_data;
  div_out_t           d_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cc <= CcWidth'(CdReset * CdReset);
    end else if (cfg_wen) begin
      cc <= CcWidth'(cfg_wdata * cfg_wdata);
    end
  end

  dec_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cc         (cc),
    .dn_valid   (f_valid),
    .dn_ready   (f_ready),
    .dn         (f_data)
  );

  dec_div u_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up       (f_data),
    .dn_valid (d_valid),
    .dn_ready (d_ready),
    .dn       (d_data)
  );

  dec_out u_out (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (d_valid),
    .up_ready     (d_ready),
    .up           (d_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  `ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid,
    "result valid straight after reset")

endmodule
